// ===== sv/aral_pkg.sv =====
// Package for the address range allocator: payload structs, status codes,
// queue command type and reset values. No dependencies.
package aral_pkg;

   localparam int MAX_RANGES_DEFAULT = 64;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [63:0] LOWEST_BASE_RESET = 64'd4096;
   localparam logic [63:0] USER_LIMIT_RESET  = 64'hFFFF_FFFF_8000_0000;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_REJECT   = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_NOTFOUND = 2'd3;

   localparam logic OP_MAP    = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   localparam logic CSR_LOWEST_BASE = 1'b0;
   localparam logic CSR_USER_LIMIT  = 1'b1;

   typedef struct packed {
      logic        opcode;
      logic [63:0] address;
      logic [63:0] length;
      logic        fixed;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] range_base;
      logic [63:0] range_end;
      logic [5:0]  slot;
   } rsp_type;

   // Classified item as it waits between front and engine
   typedef struct packed {
      logic        is_lookup;
      logic        has_hint;
      logic        hint_ovf;
      logic        fixed;
      logic [63:0] address;
      logic [63:0] length;
      logic [63:0] hint_end;
   } cmd_type;

   typedef struct packed {
      logic [63:0] lowest_base;
      logic [63:0] user_limit;
   } cfg_type;

   typedef enum logic [1:0] {
      MODE_LOOKUP = 2'd0,
      MODE_HINT   = 2'd1,
      MODE_FIRST  = 2'd2
   } mode_type;

endpackage

// ===== sv/aral_front.sv =====
// Front of the address range allocator: takes request items and classifies
// them into queue commands. Depends on aral_pkg.
module aral_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  aral_pkg::req_type  req_data,
   output logic               push,
   output aral_pkg::cmd_type  push_data,
   input  logic               queue_full
);

   logic [64:0] hint_sum;
   logic        seen_ff;
   logic        seen_in;

   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready;
   assign hint_sum  = {1'b0, req_data.address} + {1'b0, req_data.length};

   always_comb begin
      push_data.is_lookup = (req_data.opcode == aral_pkg::OP_LOOKUP);
      push_data.has_hint  = (req_data.address != 64'd0);
      push_data.hint_ovf  = hint_sum[64];
      push_data.fixed     = req_data.fixed;
      push_data.address   = req_data.address;
      push_data.length    = req_data.length;
      push_data.hint_end  = hint_sum[63:0];
   end

   // Mark that at least one item has gone through (kept for the assertion)
   assign seen_in = seen_ff || push;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else begin
         seen_ff <= seen_in;
      end
   end

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      queue_full |-> !push) else $error("push into full queue");
   a_push_marks_seen: assert property (@(posedge clock) disable iff (reset)
      push |=> seen_ff) else $error("seen flag not set");
   a_ready_tracks_queue: assert property (@(posedge clock) disable iff (reset)
      req_valid && !queue_full |-> push) else $error("item not taken");
`endif

endmodule

// ===== sv/aral_queue.sv =====
// Two-entry command queue between front and engine of the range allocator.
// Depends on aral_pkg.
module aral_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  aral_pkg::cmd_type  push_data,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output aral_pkg::cmd_type  pop_data
);

   localparam int PW = $clog2(aral_pkg::QUEUE_DEPTH);
   localparam int FW = $clog2(aral_pkg::QUEUE_DEPTH + 1);

   aral_pkg::cmd_type slots_ff [aral_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [FW-1:0] fill_ff, fill_in;

   assign full      = (fill_ff == FW'(aral_pkg::QUEUE_DEPTH));
   assign not_empty = (fill_ff != '0);
   assign pop_data  = slots_ff[rd_ff];

   always_comb begin
      wr_in   = push ? PW'(wr_ff + 1'b1) : wr_ff;
      rd_in   = pop  ? PW'(rd_ff + 1'b1) : rd_ff;
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = FW'(fill_ff + 1'b1);
      end else if (pop && !push) begin
         fill_in = FW'(fill_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty) else $error("pop from empty queue");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> !full) else $error("push into full queue");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(aral_pkg::QUEUE_DEPTH)) else $error("fill count out of range");
`endif

endmodule

// ===== sv/aral_engine.sv =====
// Engine of the range allocator: walks the sorted range memory, shifts entries
// to insert, and holds the result register. Depends on aral_pkg.
module aral_engine #(
   parameter int MAX_RANGES = aral_pkg::MAX_RANGES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  aral_pkg::cfg_type  cfg,
   input  logic               cmd_valid,
   input  aral_pkg::cmd_type  cmd,
   output logic               cmd_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output aral_pkg::rsp_type  rsp_data
);

   localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int CW = $clog2(MAX_RANGES + 1);

   typedef enum logic [4:0] {
      S_IDLE     = 5'b00001,
      S_WALK     = 5'b00010,
      S_SHIFT_RD = 5'b00100,
      S_SHIFT_WR = 5'b01000,
      S_INSERT   = 5'b10000
   } state_type;

   logic [127:0] mem [MAX_RANGES];
   logic [127:0] rd_q;
   logic [IW-1:0] rd_idx, wr_idx;
   logic [127:0] wr_word;
   logic         mem_we;

   state_type          state_ff, state_in;
   aral_pkg::mode_type mode_ff, mode_in;
   logic [CW-1:0] k_ff, k_in, pos_ff, pos_in, j_ff, j_in, count_ff, count_in;
   logic [63:0]   b_ff, b_in, e_ff, e_in, len_ff, len_in, prev_end_ff, prev_end_in;
   logic          fixed_ff, fixed_in;
   logic          rsp_valid_ff, rsp_valid_in;
   aral_pkg::rsp_type rsp_ff, rsp_in;
   logic          rsp_load;

   logic [63:0]   add_a, add_b;
   logic [64:0]   sum;
   logic [63:0]   rb, re;
   logic          at_end, ovl, slot_free;
   logic [CW+5:0] slot_wide;

   assign rb = rd_q[127:64];
   assign re = rd_q[63:0];
   assign at_end    = (k_ff == count_ff);
   assign ovl       = (b_ff >= rb && b_ff < re) || (e_ff > rb && e_ff <= re)
                      || (b_ff < rb && e_ff > re);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign sum       = {1'b0, add_a} + {1'b0, add_b};
   assign slot_wide = {6'd0, pos_ff};

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      k_in        = k_ff;
      pos_in      = pos_ff;
      j_in        = j_ff;
      count_in    = count_ff;
      b_in        = b_ff;
      e_in        = e_ff;
      len_in      = len_ff;
      prev_end_in = prev_end_ff;
      fixed_in    = fixed_ff;
      cmd_pop     = 1'b0;
      mem_we      = 1'b0;
      wr_idx      = j_ff[IW-1:0];
      wr_word     = rd_q;
      rd_idx      = '0;
      add_a       = cfg.lowest_base;
      add_b       = len_ff;
      rsp_load    = 1'b0;
      rsp_in      = '{status: aral_pkg::ST_REJECT, range_base: 64'd0,
                      range_end: 64'd0, slot: 6'd0};
      case (state_ff)
         S_IDLE: begin
            add_b = cmd.length;
            if (cmd_valid && slot_free) begin
               cmd_pop  = 1'b1;
               len_in   = cmd.length;
               fixed_in = cmd.fixed;
               k_in     = '0;
               pos_in   = '0;
               if (cmd.is_lookup) begin
                  mode_in  = aral_pkg::MODE_LOOKUP;
                  b_in     = cmd.address;
                  state_in = S_WALK;
               end else if (count_ff == CW'(MAX_RANGES)) begin
                  rsp_load      = 1'b1;
                  rsp_in.status = aral_pkg::ST_FULL;
               end else if (cmd.has_hint && !cmd.hint_ovf) begin
                  mode_in  = aral_pkg::MODE_HINT;
                  b_in     = cmd.address;
                  e_in     = cmd.hint_end;
                  state_in = S_WALK;
               end else if ((cmd.has_hint && cmd.fixed) || sum[64]) begin
                  rsp_load = 1'b1;
               end else begin
                  mode_in  = aral_pkg::MODE_FIRST;
                  b_in     = cfg.lowest_base;
                  e_in     = sum[63:0];
                  state_in = S_WALK;
               end
            end
         end
         S_WALK: begin
            rd_idx = IW'(k_ff + CW'(1));
            case (mode_ff)
               aral_pkg::MODE_LOOKUP: begin
                  if (at_end) begin
                     rsp_load      = 1'b1;
                     rsp_in.status = aral_pkg::ST_NOTFOUND;
                     state_in      = S_IDLE;
                  end else if (b_ff >= rb && b_ff <= re) begin
                     rsp_load = 1'b1;
                     rsp_in   = '{status: aral_pkg::ST_OK, range_base: rb,
                                  range_end: re, slot: 6'd0};
                     rsp_in.slot = 6'({6'd0, k_ff});
                     state_in = S_IDLE;
                  end else begin
                     k_in = CW'(k_ff + CW'(1));
                  end
               end
               aral_pkg::MODE_HINT: begin
                  if (at_end && (count_ff == '0 || prev_end_ff <= b_ff)) begin
                     pos_in   = count_ff;
                     j_in     = count_ff;
                     state_in = S_SHIFT_RD;
                  end else if (!at_end && !ovl && re > b_ff && rb >= e_ff) begin
                     j_in     = count_ff;
                     state_in = S_SHIFT_RD;
                  end else if (!at_end && !ovl) begin
                     // Entry lies wholly below the hint or straddles nothing
                     if (re <= b_ff) begin
                        pos_in = CW'(pos_ff + CW'(1));
                     end
                     prev_end_in = re;
                     k_in        = CW'(k_ff + CW'(1));
                  end else begin
                     // Hint failed: drop to first fit unless fixed or the first-fit end overflows
                     if (fixed_ff || sum[64]) begin
                        rsp_load = 1'b1;
                        state_in = S_IDLE;
                     end else begin
                        mode_in = aral_pkg::MODE_FIRST;
                        b_in    = cfg.lowest_base;
                        e_in    = sum[63:0];
                        k_in    = '0;
                        pos_in  = '0;
                        rd_idx  = '0;
                     end
                  end
               end
               default: begin
                  add_a = re;
                  if (at_end) begin
                     if (e_ff < cfg.user_limit) begin
                        pos_in   = count_ff;
                        j_in     = count_ff;
                        state_in = S_SHIFT_RD;
                     end else begin
                        rsp_load = 1'b1;
                        state_in = S_IDLE;
                     end
                  end else if (rb >= e_ff) begin
                     pos_in   = k_ff;
                     j_in     = count_ff;
                     state_in = S_SHIFT_RD;
                  end else if (ovl && sum[64]) begin
                     rsp_load = 1'b1;
                     state_in = S_IDLE;
                  end else begin
                     if (ovl) begin
                        b_in = re;
                        e_in = sum[63:0];
                     end
                     k_in = CW'(k_ff + CW'(1));
                  end
               end
            endcase
         end
         S_SHIFT_RD: begin
            rd_idx = IW'(j_ff - CW'(1));
            state_in = (j_ff == pos_ff) ? S_INSERT : S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            mem_we   = 1'b1;
            j_in     = CW'(j_ff - CW'(1));
            state_in = S_SHIFT_RD;
         end
         S_INSERT: begin
            mem_we   = 1'b1;
            wr_idx   = pos_ff[IW-1:0];
            wr_word  = {b_ff, e_ff};
            count_in = CW'(count_ff + CW'(1));
            rsp_load = 1'b1;
            rsp_in   = '{status: aral_pkg::ST_OK, range_base: b_ff,
                         range_end: e_ff, slot: slot_wide[5:0]};
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      k_ff        <= k_in;
      pos_ff      <= pos_in;
      j_ff        <= j_in;
      b_ff        <= b_in;
      e_ff        <= e_in;
      len_ff      <= len_in;
      prev_end_ff <= prev_end_in;
      fixed_ff    <= fixed_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_idx] <= wr_word;
      end
      rd_q <= mem[rd_idx];
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_RANGES)) else $error("range count above table size");
   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_INSERT |-> count_ff < CW'(MAX_RANGES)) else $error("insert into full table");
   a_walk_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WALK |-> pos_ff <= k_ff && k_ff <= count_ff)
      else $error("walk index out of order");
   a_result_not_lost: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> slot_free) else $error("result overwrites waiting item");
`endif

endmodule

// ===== sv/address_range_allocator_top.sv =====
// Address range allocator: first-fit and hinted placement over a sorted table.
// Lookup walks the table entry by entry until a hit or the end; map walks the table,
// walks it again from the start on a hint fallback, then shifts entries up (read, write).
// Throughput: one item at a time in the engine; the memory port sets the pace.
// Reset: synchronous, active high; table empties at once, config registers take defaults.
// Depends on aral_pkg, aral_front, aral_queue and aral_engine.
module address_range_allocator_top #(
   parameter int MAX_RANGES = aral_pkg::MAX_RANGES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  aral_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output aral_pkg::rsp_type  rsp_data,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [63:0]        pwdata,
   output logic [63:0]        prdata,
   output logic               pready
);

   aral_pkg::cfg_type cfg_ff, cfg_in;
   aral_pkg::cmd_type push_data, pop_data;
   logic push, pop, queue_full, queue_not_empty;
   logic csr_write;

   // Registers sit at 8-byte strides: address bit 3 picks the register
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         if (paddr[3] == aral_pkg::CSR_LOWEST_BASE) begin
            cfg_in.lowest_base = pwdata;
         end else begin
            cfg_in.user_limit = pwdata;
         end
      end
      prdata = (paddr[3] == aral_pkg::CSR_USER_LIMIT) ? cfg_ff.user_limit
                                                      : cfg_ff.lowest_base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lowest_base <= aral_pkg::LOWEST_BASE_RESET;
         cfg_ff.user_limit  <= aral_pkg::USER_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: take items, work out hint end and overflow
   aral_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push       (push),
      .push_data  (push_data),
      .queue_full (queue_full)
   );

   // Hold classified items while the engine walks
   aral_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (queue_not_empty),
      .pop_data  (pop_data)
   );

   // Engine: walk, shift, insert, and deliver results
   aral_engine #(
      .MAX_RANGES (MAX_RANGES)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (queue_not_empty),
      .cmd       (pop_data),
      .cmd_pop   (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
